>>> rtl/spectrum_magnitude_smoother_defines.svh
// Assertion macros shared by the spectrum magnitude smoother RTL.
// Needs a clock and a reset signal in the scope where a macro is used.
`ifndef SPECTRUM_MAGNITUDE_SMOOTHER_DEFINES_SVH
`define SPECTRUM_MAGNITUDE_SMOOTHER_DEFINES_SVH

// expr must hold at every clock edge outside reset
`define SMS_ASSERT_HOLDS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// cons must hold in the cycle after ante
`define SMS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sms_pkg.sv
// Shared types and fixed widths for the spectrum magnitude smoother.
// No dependencies.
package sms_pkg;

   localparam int SAMPLE_BITS = 16;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] bin_real;
      logic signed [SAMPLE_BITS-1:0] bin_imag;
      logic                          frame_end;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] smooth_real;
      logic signed [SAMPLE_BITS-1:0] smooth_imag;
      logic                          frame_done;
   } rsp_type;

endpackage

>>> rtl/sms_div.sv
// Restoring divider, one quotient bit per cycle.
// Standalone; no package needed.
module sms_div #(
   parameter int W = 34
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);
   localparam int CW = $clog2(W + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [W-1:0]  rem_ff;
   logic [W-1:0]  quo_ff;
   logic [W-1:0]  dvs_ff;
   logic [W:0]    trial;
   logic [W:0]    diff;

   always_comb begin
      trial = {rem_ff, quo_ff[W-1]};
      diff  = trial - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            if (trial >= {1'b0, dvs_ff}) begin
               rem_ff <= diff[W-1:0];
               quo_ff <= {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_ff <= trial[W-1:0];
               quo_ff <= {quo_ff[W-2:0], 1'b0};
            end
            if (cnt_ff == CW'(W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff + CW'(1);
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

>>> rtl/sms_isqrt.sv
// Integer square root, one result bit per cycle (floor of sqrt).
// Standalone; no package needed.
module sms_isqrt #(
   parameter int W = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [2*W-1:0] radicand,
   output logic           done,
   output logic [W-1:0]   root
);
   localparam int CW = $clog2(W + 1);

   logic           busy_ff;
   logic           done_ff;
   logic [CW-1:0]  cnt_ff;
   logic [2*W-1:0] x_ff;
   logic [2*W-1:0] r_ff;
   logic [2*W-1:0] bit_ff;
   logic [2*W-1:0] trial;

   assign trial = r_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            x_ff    <= radicand;
            r_ff    <= '0;
            bit_ff  <= {2'b01, {(2*W-2){1'b0}}};
         end else if (busy_ff) begin
            if (x_ff >= trial) begin
               x_ff <= x_ff - trial;
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (cnt_ff == CW'(W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff + CW'(1);
         end
      end
   end

   assign done = done_ff;
   assign root = r_ff[W-1:0];
endmodule

>>> rtl/spectrum_magnitude_smoother.sv
// Top level of the spectrum magnitude smoother: bin rings, window sum, scaling.
// Depends on sms_pkg, sms_div, sms_isqrt and spectrum_magnitude_smoother_defines.svh.
//
//   channel | ports                      | beat
//   --------+----------------------------+---------------------------------
//   input   | req_valid req_stall req_beat | one bin (re, im, frame_end)
//   result  | rsp_valid rsp_stall rsp_beat | one smoothed bin (re, im, done)
//   config  | csr_wr_en csr_wr_data      | tap count, 7 bits
//
// One bin at a time. Per accepted bin: two squares, 16-step root, ring write.
// Per result: 2h window reads from the magnitude ring (one read port), then 3 serial
// divides of 2*16+2 steps (the average, then the real and the imaginary part).
// Synchronous active-high reset clears control state; rings need no clearing.
// A stalled result holds; no new bin is taken until all its results are out.
`include "spectrum_magnitude_smoother_defines.svh"

module spectrum_magnitude_smoother
   import sms_pkg::*;
#(
   parameter int MAX_TAPS       = 64,
   parameter int MAX_FRAME_LOG2 = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_beat,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_beat,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data
);
   localparam int S  = SAMPLE_BITS;
   localparam int MW = S + 1;                       // magnitude width
   localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int TW = $clog2(MAX_TAPS + 1);        // taps, half, pending, window count
   localparam int SW = MW + $clog2(MAX_TAPS);       // window sum
   localparam int DW = 2 * S + 2;                   // divider width
   localparam int IW = MAX_FRAME_LOG2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQR, ST_ROOT_GO, ST_ROOT, ST_DECIDE, ST_WIN, ST_WTAIL,
      ST_LOAD, ST_AVG, ST_MUL, ST_QGO, ST_QUO, ST_OUT
   } state_type;

   state_type state_ff;

   logic [6:0]     taps_ff;
   logic [TW-1:0]  ftaps_ff;      // taps latched for the frame
   logic [TW-1:0]  half_ff;
   logic [S-1:0]   re_ff, im_ff;
   logic           end_ff;
   logic [S-1:0]   ar_ff, ai_ff;
   logic [2*S-1:0] sqr_ff, sqi_ff;
   logic           rt_start_ff;
   logic [AW-1:0]  wr_pos_ff;
   logic [TW-1:0]  pending_ff;
   logic [IW-1:0]  bin_index_ff, emit_index_ff;
   logic [AW-1:0]  pos_ff, rptr_ff;
   logic [TW-1:0]  k_ff;
   logic           inc_ff, rdv_ff;
   logic [SW-1:0]  sum_ff;        // window_sum
   logic [MW-1:0]  mag_ff, avg_ff;
   logic [2*S-1:0] bin_ff;
   logic           sel_ff, negp_ff;
   logic [2*S:0]   prod_ff;
   logic           div_start_ff;
   logic [DW-1:0]  dvd_ff, dvs_ff;
   logic [S-1:0]   res_re_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   // rings
   logic [MW-1:0]  mag_mem [MAX_TAPS];
   logic [2*S-1:0] bin_mem [MAX_TAPS];
   logic [MW-1:0]  mag_rd_ff;
   logic [2*S-1:0] bin_rd_ff;
   logic [AW-1:0]  mag_raddr;

   logic           rt_done, div_done;
   logic [S-1:0]   rt_root;
   logic [DW-1:0]  div_quo;
   logic [2*S-1:0] radicand;
   logic           ring_we;

   logic [AW-1:0]  pos_c;
   logic           include_c;
   logic [S-1:0]   part_c;
   logic [S-1:0]   sat_c;
   logic [TW-1:0]  taps_c;

   function automatic logic [S-1:0] abs_part(input logic [S-1:0] v);
      return v[S-1] ? (~v + S'(1)) : v;
   endfunction

   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [31:0] b);
      logic [31:0] s;
      s = 32'(a) + b;
      if (s >= 32'(MAX_TAPS)) begin
         s = s - 32'(MAX_TAPS);
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [S-1:0] saturate(input logic [DW-1:0] q, input logic neg);
      logic [DW-1:0] lim;
      logic [DW-1:0] qc;
      lim = DW'(1) << (S - 1);
      if (neg) begin
         qc = (q > lim) ? lim : q;
         return ~qc[S-1:0] + S'(1);
      end
      qc = (q > lim - DW'(1)) ? (lim - DW'(1)) : q;
      return qc[S-1:0];
   endfunction

   assign radicand = sqr_ff + sqi_ff;
   assign ring_we  = (state_ff == ST_ROOT) && rt_done;
   assign mag_raddr = (state_ff == ST_WIN) ? rptr_ff : pos_ff;

   always_comb begin
      // oldest pending bin, and whether window offset k lies inside the frame
      pos_c = ring_add(wr_pos_ff, 32'(MAX_TAPS) - 32'(pending_ff));
      if (k_ff < half_ff) begin
         include_c = 32'(half_ff - k_ff) <= 32'(emit_index_ff);
      end else begin
         include_c = 32'(k_ff - half_ff) < 32'(pending_ff);
      end
      part_c = sel_ff ? bin_ff[2*S-1:S] : bin_ff[S-1:0];
      sat_c  = (mag_ff == '0) ? '0 : saturate(div_quo, negp_ff);
      if (taps_ff < 7'd2) begin
         taps_c = TW'(2);
      end else if (32'(taps_ff) > 32'(MAX_TAPS)) begin
         taps_c = TW'(MAX_TAPS);
      end else begin
         taps_c = TW'(taps_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         mag_mem[wr_pos_ff] <= MW'(rt_root);
         bin_mem[wr_pos_ff] <= {im_ff, re_ff};
      end
      mag_rd_ff <= mag_mem[mag_raddr];
      bin_rd_ff <= bin_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         taps_ff       <= 7'd8;
         ftaps_ff      <= '0;
         half_ff       <= '0;
         wr_pos_ff     <= '0;
         pending_ff    <= '0;
         bin_index_ff  <= '0;
         emit_index_ff <= '0;
         sum_ff        <= '0;
         rt_start_ff   <= 1'b0;
         div_start_ff  <= 1'b0;
         rdv_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rt_start_ff  <= 1'b0;
         div_start_ff <= 1'b0;
         if (csr_wr_en) begin
            taps_ff <= csr_wr_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  re_ff  <= req_beat.bin_real;
                  im_ff  <= req_beat.bin_imag;
                  end_ff <= req_beat.frame_end;
                  ar_ff  <= abs_part(req_beat.bin_real);
                  ai_ff  <= abs_part(req_beat.bin_imag);
                  if (bin_index_ff == '0) begin
                     ftaps_ff <= taps_c;
                     half_ff  <= taps_c >> 1;
                  end
                  state_ff <= ST_SQR;
               end
            end
            ST_SQR: begin
               sqr_ff   <= (2*S)'(ar_ff) * (2*S)'(ar_ff);
               sqi_ff   <= (2*S)'(ai_ff) * (2*S)'(ai_ff);
               state_ff <= ST_ROOT_GO;
            end
            ST_ROOT_GO: begin
               rt_start_ff <= 1'b1;
               state_ff    <= ST_ROOT;
            end
            ST_ROOT: begin
               if (rt_done) begin
                  wr_pos_ff  <= ring_add(wr_pos_ff, 32'd1);
                  pending_ff <= pending_ff + TW'(1);
                  if (bin_index_ff != '1) begin
                     bin_index_ff <= bin_index_ff + IW'(1);
                  end
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (end_ff || pending_ff >= half_ff) begin
                  pos_ff   <= pos_c;
                  rptr_ff  <= ring_add(pos_c, 32'(MAX_TAPS) - 32'(half_ff));
                  k_ff     <= '0;
                  sum_ff   <= '0;
                  rdv_ff   <= 1'b0;
                  state_ff <= ST_WIN;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_WIN: begin
               // address k issued now; data for k-1 lands in mag_rd_ff
               rdv_ff  <= 1'b1;
               inc_ff  <= include_c;
               rptr_ff <= ring_add(rptr_ff, 32'd1);
               if (rdv_ff && inc_ff) begin
                  sum_ff <= sum_ff + SW'(mag_rd_ff);
               end
               if ((TW+1)'(k_ff) == {half_ff, 1'b0} - (TW+1)'(1)) begin
                  state_ff <= ST_WTAIL;
               end else begin
                  k_ff <= k_ff + TW'(1);
               end
            end
            ST_WTAIL: begin
               if (rdv_ff && inc_ff) begin
                  sum_ff <= sum_ff + SW'(mag_rd_ff);
               end
               rdv_ff   <= 1'b0;
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               mag_ff       <= mag_rd_ff;
               bin_ff       <= bin_rd_ff;
               dvd_ff       <= DW'(sum_ff);
               dvs_ff       <= DW'(ftaps_ff);
               div_start_ff <= 1'b1;
               state_ff     <= ST_AVG;
            end
            ST_AVG: begin
               if (div_done) begin
                  avg_ff   <= div_quo[MW-1:0];
                  sel_ff   <= 1'b0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               negp_ff  <= part_c[S-1];
               prod_ff  <= (2*S+1)'(abs_part(part_c)) * (2*S+1)'(avg_ff);
               state_ff <= ST_QGO;
            end
            ST_QGO: begin
               // round half away: (2p + mag) / (2 mag)
               dvd_ff       <= {prod_ff, 1'b0} + DW'(mag_ff);
               dvs_ff       <= DW'({mag_ff, 1'b0});
               div_start_ff <= 1'b1;
               state_ff     <= ST_QUO;
            end
            ST_QUO: begin
               if (div_done) begin
                  if (!sel_ff) begin
                     res_re_ff <= sat_c;
                     sel_ff    <= 1'b1;
                     state_ff  <= ST_MUL;
                  end else begin
                     rsp_ff.smooth_real <= res_re_ff;
                     rsp_ff.smooth_imag <= sat_c;
                     rsp_ff.frame_done  <= end_ff && (pending_ff == TW'(1));
                     rsp_valid_ff       <= 1'b1;
                     state_ff           <= ST_OUT;
                  end
               end
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  pending_ff   <= pending_ff - TW'(1);
                  if (emit_index_ff != '1) begin
                     emit_index_ff <= emit_index_ff + IW'(1);
                  end
                  if (end_ff && pending_ff == TW'(1)) begin
                     // frame flushed
                     bin_index_ff  <= '0;
                     emit_index_ff <= '0;
                     pending_ff    <= '0;
                     state_ff      <= ST_IDLE;
                  end else if (end_ff) begin
                     state_ff <= ST_DECIDE;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   sms_isqrt #(.W(S)) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (rt_start_ff),
      .radicand (radicand),
      .done     (rt_done),
      .root     (rt_root)
   );

   sms_div #(.W(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (dvd_ff),
      .divisor  (dvs_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   `SMS_ASSERT_HOLDS(a_pending_bound, 32'(pending_ff) <= 32'(MAX_TAPS / 2), "pending bins exceed half window")
   `SMS_ASSERT_HOLDS(a_result_blocks_input, !rsp_valid_ff || req_stall, "input taken while a result waits")
   `SMS_ASSERT_NEXT(a_frame_flush, rsp_valid && !rsp_stall && rsp_beat.frame_done, pending_ff == '0 && bin_index_ff == '0, "frame state not cleared after last result")
endmodule

>>> tb/sms_checker.sv
// Checker for the spectrum magnitude smoother: watches both channels and the tap register,
// predicts the smoothed bins and compares them. Depends on sms_pkg.
module sms_checker
   import sms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_beat,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  rsp_type    rsp_beat,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data,
   output int         fail_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING = 64;

   logic [31:0] raw_ring [RING];
   logic [16:0] mag_ring [RING];
   int          bins_seen, emitted, queued, wr_ptr, tap_reg, frame_tap_count, frame_reach;
   rsp_type     smooth_queue [$];

   function automatic logic [16:0] root_of(logic [31:0] x);
      logic [16:0] r;
      r = 0;
      for (int b = 16; b >= 0; b--)
         if ((r | (17'd1 << b)) * (r | (17'd1 << b)) <= 64'(x)) r = r | (17'd1 << b);
      return r;
   endfunction

   function automatic logic [15:0] scaled_part(logic signed [15:0] part, longint avg,
                                               longint mag);
      longint a, q;
      if (mag == 0) return 16'd0;
      a = part < 0 ? -longint'(part) : longint'(part);
      q = (2 * a * avg + mag) / (2 * mag);
      if (part < 0) return 16'(-((q > 32768) ? 32768 : q));
      return 16'((q > 32767) ? 32767 : q);
   endfunction

   task automatic predict_one(logic done);
      int pos;
      longint sum, avg;
      rsp_type r;
      pos = (wr_ptr + RING - queued) % RING;
      sum = 0;
      for (int j = -frame_reach; j < frame_reach; j++) begin
         if (j < 0 && -j > emitted) continue;
         if (j >= 0 && j >= queued) continue;
         sum += mag_ring[(pos + RING + j) % RING];
      end
      avg = sum / frame_tap_count;
      r.smooth_real = scaled_part(raw_ring[pos][15:0], avg, mag_ring[pos]);
      r.smooth_imag = scaled_part(raw_ring[pos][31:16], avg, mag_ring[pos]);
      r.frame_done = done;
      smooth_queue.push_back(r);
      queued--;
      if (emitted < 65535) emitted++;
   endtask

   task automatic take_bin(req_type b);
      logic signed [31:0] re, im;
      if (bins_seen == 0) begin
         frame_tap_count = tap_reg < 2 ? 2 : (tap_reg > 64 ? 64 : tap_reg);
         frame_reach = frame_tap_count / 2;
      end
      re = b.bin_real;
      im = b.bin_imag;
      raw_ring[wr_ptr] = {b.bin_imag, b.bin_real};
      mag_ring[wr_ptr] = root_of(32'(re * re + im * im));
      wr_ptr = (wr_ptr + 1) % RING;
      queued++;
      if (bins_seen < 65535) bins_seen++;
      if (b.frame_end) begin
         while (queued > 0) predict_one(queued == 1);
         bins_seen = 0;
         emitted = 0;
      end else if (queued >= frame_reach) predict_one(1'b0);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         bins_seen = 0; emitted = 0; queued = 0; wr_ptr = 0; tap_reg = 8;
         fail_count = 0;
         smooth_queue.delete();
      end else begin
         if (csr_wr_en) tap_reg = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (smooth_queue.size() == 0) begin
               $error("unexpected result beat %h", rsp_beat);
               fail_count++;
            end else begin
               want = smooth_queue.pop_front();
               if (rsp_beat.smooth_real !== want.smooth_real) begin
                  $error("smooth_real: expected %0d actual %0d",
                         want.smooth_real, rsp_beat.smooth_real);
                  fail_count++;
               end
               if (rsp_beat.smooth_imag !== want.smooth_imag) begin
                  $error("smooth_imag: expected %0d actual %0d",
                         want.smooth_imag, rsp_beat.smooth_imag);
                  fail_count++;
               end
               if (rsp_beat.frame_done !== want.frame_done) begin
                  $error("frame_done: expected %0d actual %0d",
                         want.frame_done, rsp_beat.frame_done);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) take_bin(req_beat);
      end
      pending_count = smooth_queue.size() + queued;
   end
endmodule

>>> tb/tb_spectrum_magnitude_smoother.sv
// Testbench top for the spectrum magnitude smoother: clock, reset, bin frames, tap
// settings, receiver stalls and the verdict. Depends on sms_pkg, sms_checker and spectrum_magnitude_smoother.
module tb_spectrum_magnitude_smoother;
   import sms_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock, reset;
   logic       req_valid, req_stall, rsp_valid, rsp_stall;
   req_type    req_beat;
   rsp_type    rsp_beat;
   logic       csr_wr_en;
   logic [6:0] csr_wr_data;
   int         fail_count, pending_count;
   bit         hold_rsp;   // long receiver hold-off request

   spectrum_magnitude_smoother dut (
      .clock, .reset, .req_valid, .req_stall, .req_beat,
      .rsp_valid, .rsp_stall, .rsp_beat, .csr_wr_en, .csr_wr_data
   );

   sms_checker checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_beat,
      .rsp_valid, .rsp_stall, .rsp_beat, .csr_wr_en, .csr_wr_data,
      .fail_count, .pending_count
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Receiver: stall pattern switches among none, light and heavy; hold_rsp forces
   // a long stretch of stall counted here.
   initial begin
      int mode, left;
      rsp_stall = 0;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1;
            repeat (600) @(posedge clock);
            hold_rsp = 0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(20, 300);
         end
         left--;
         case (mode)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // One beat; valid stays high across back-to-back beats. Gap only between bursts.
   int burst_left;
   task automatic send_bin(logic signed [15:0] re, logic signed [15:0] im, logic last);
      req_valid <= 1;
      req_beat  <= '{bin_real: re, bin_imag: im, frame_end: last};
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 12);
         req_valid <= 0;
         repeat ($urandom_range(1, 25)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);   // pause after the last result is out
   endtask

   task automatic set_taps(int t);
      drain();
      csr_wr_en   <= 1;
      csr_wr_data <= 7'(t);
      @(posedge clock);
      csr_wr_en   <= 0;
   endtask

   function automatic logic signed [15:0] rand_part();
      case ($urandom_range(0, 5))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'(signed'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_frame(int len);
      for (int i = 0; i < len; i++) send_bin(rand_part(), rand_part(), i == len - 1);
   endtask

   initial begin
      int tap_set [7] = '{0, 1, 2, 3, 64, 127, 17};
      int n;
      reset = 1;
      req_valid = 0;
      req_beat = '0;
      csr_wr_en = 0;
      csr_wr_data = 0;
      hold_rsp = 0;
      burst_left = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, zero-magnitude bins, single-bin frame, reset taps.
      send_bin(-16'sd32768, -16'sd32768, 0);
      send_bin(16'sd32767, 16'sd32767, 0);
      send_bin(0, 0, 0);
      send_bin(16'sd32767, -16'sd32768, 0);
      send_bin(1, 0, 0);
      send_bin(0, -1, 0);
      send_bin(-16'sd32768, 0, 0);
      send_bin(16'sd100, 16'sd3, 1);
      send_bin(0, 0, 1);
      // Mid-frame tap write: with two taps every bin's result is out at once, so the
      // write lands inside the frame with nothing outstanding; used by the next frame.
      set_taps(2);
      send_bin(16'sd5000, -16'sd7000, 0);
      send_bin(-16'sd1, 16'sd1, 0);
      set_taps(8);
      send_bin(16'sd300, 16'sd400, 0);
      send_bin(16'sd2, -16'sd2, 1);
      send_bin(16'sd2, -16'sd2, 0);
      send_bin(-16'sd32768, 16'sd32767, 1);

      // Long receiver hold-off while the sender keeps offering bins.
      hold_rsp = 1;
      random_frame(20);
      drain();   // sender pause until every result is out

      for (int s = 0; s < 7; s++) begin
         set_taps(tap_set[s]);
         repeat (3) random_frame($urandom_range(1, 16));
      end
      set_taps(64);
      random_frame(90);   // long frame, ring wraps
      set_taps($urandom_range(2, 20));
      n = 0;
      while (n < 60) begin
         int len;
         len = $urandom_range(1, 10);
         random_frame(len);
         n += len;
      end
      drain();

      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #60ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule

>>> spectrum_magnitude_smoother.f
+incdir+rtl
rtl/sms_pkg.sv
rtl/sms_div.sv
rtl/sms_isqrt.sv
rtl/spectrum_magnitude_smoother.sv
tb/sms_checker.sv
tb/tb_spectrum_magnitude_smoother.sv
